>>> design/vlft_pkg.sv
// Shared constants, types and the register map for the video line/frame timing block.
package vlft_pkg;

  localparam int CYCLES_W = 10;
  localparam int DOTS_W   = 11;
  localparam int ACC_W    = 13;
  localparam int LINE_W   = 9;

  // 11/7 scale as one constant multiply: floor(c * 102993 / 2^16) == floor(11c/7)
  // for every 10-bit c (the reciprocal overshoot stays under one seventh).
  localparam int SCALE_SHIFT = 16;
  localparam int PROD_W      = CYCLES_W + 17;
  localparam logic [PROD_W-1:0] SCALE_MUL = PROD_W'(102993);

  localparam logic [ACC_W-1:0]  DOTS_NTSC      = ACC_W'(3412);
  localparam logic [ACC_W-1:0]  DOTS_PAL       = ACC_W'(3404);
  localparam logic [LINE_W-1:0] LAST_LINE_NTSC = LINE_W'(263);
  localparam logic [LINE_W-1:0] LAST_LINE_PAL  = LINE_W'(314);

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIDEO_STANDARD = 2'd0,
    REG_VERTICAL_480   = 2'd1,
    REG_INTERLACE      = 2'd2
  } vlft_reg_t;

  typedef struct packed {
    logic video_standard;
    logic vertical_480;
    logic interlace_enable;
  } vlft_cfg_t;

  // Word handed from the scaling stage to the timing stage.
  typedef struct packed {
    logic              valid;
    logic [DOTS_W-1:0] dots;
  } vlft_dots_t;

endpackage

>>> design/vlft_scale.sv
// Input stage: register the cycle count already scaled to dot clocks.
module vlft_scale import vlft_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [CYCLES_W-1:0] cycles,
  input  logic                take,     // timing stage consumes the held word
  output vlft_dots_t          stage
);

  logic              valid_r;
  logic              valid_nxt;
  logic [DOTS_W-1:0] dots_r;
  logic [PROD_W-1:0] prod;

  assign prod      = PROD_W'(cycles) * SCALE_MUL;
  assign in_tready = !valid_r || take;
  assign valid_nxt = in_tvalid || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      dots_r <= prod[SCALE_SHIFT +: DOTS_W];
    end
  end

  assign stage.valid = valid_r;
  assign stage.dots  = dots_r;

endmodule

>>> design/vlft_timing.sv
// Timing stage: dot accumulator, scanline counter, odd flag and the result register.
module vlft_timing import vlft_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  vlft_cfg_t         cfg,
  input  vlft_dots_t        stage,
  output logic              take,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              hblank,
  output logic              vblank,
  output logic              odd_line,
  output logic [LINE_W-1:0] line_number
);

  logic [ACC_W-1:0]  acc_r,  acc_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              odd_r,  odd_nxt;
  logic              valid_r;
  logic              hb_r, hb_nxt;
  logic              vb_r, vb_nxt;

  logic [ACC_W-1:0]  line_len;
  logic [LINE_W-1:0] last_line;
  logic [ACC_W-1:0]  acc_sum;
  logic [LINE_W-1:0] line_inc;
  logic              step;

  assign take      = !valid_r || out_tready;
  assign step      = stage.valid && take;
  assign line_len  = cfg.video_standard ? DOTS_PAL : DOTS_NTSC;
  assign last_line = cfg.video_standard ? LAST_LINE_PAL : LAST_LINE_NTSC;
  assign acc_sum   = acc_r + ACC_W'(stage.dots);
  assign line_inc  = line_r + LINE_W'(1);

  always_comb begin
    acc_nxt  = acc_sum;
    line_nxt = line_r;
    odd_nxt  = odd_r;
    hb_nxt   = 1'b0;
    vb_nxt   = 1'b0;
    // line completes only when the accumulator goes past a full line
    if (acc_sum > line_len) begin
      acc_nxt  = acc_sum - line_len;
      hb_nxt   = 1'b1;
      line_nxt = line_inc;
      // parity comes from the incremented line, before any wrap
      if (cfg.vertical_480) begin
        odd_nxt = line_inc[0];
      end
      if (line_inc > last_line) begin
        line_nxt = '0;
        vb_nxt   = 1'b1;
        if (cfg.interlace_enable && cfg.vertical_480) begin
          odd_nxt = !odd_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      line_r  <= '0;
      odd_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (take) begin
        valid_r <= stage.valid;
      end
      if (step) begin
        acc_r  <= acc_nxt;
        line_r <= line_nxt;
        odd_r  <= odd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hb_r <= hb_nxt;
      vb_r <= vb_nxt;
    end
  end

  assign out_tvalid  = valid_r;
  assign hblank      = hb_r;
  assign vblank      = vb_r;
  assign odd_line    = odd_r;
  assign line_number = line_r;

  // a frame wrap is always a completed line that lands on line 0
  a_vblank_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && vb_r |-> hb_r && (line_r == '0))
    else $error("vblank without hblank or nonzero line");

  a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_r <= LAST_LINE_PAL)
    else $error("scanline counter beyond last PAL line");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= DOTS_NTSC)
    else $error("dot accumulator beyond one line");

  a_odd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && !cfg.vertical_480 |=> $stable(odd_r))
    else $error("odd flag moved outside 480-line mode");

endmodule

>>> design/video_line_frame_timing.sv
// Top level of the video line/frame timing block: config registers and the two-stage pipe.
//
// Each input word carries a CPU cycle count; the block scales it to dot clocks
// (11/7, truncated per word), adds it to a dot accumulator, and reports one
// result word per input word: hblank when a line completed, vblank when the
// frame wrapped to line 0, the odd-line/odd-field bit and the current line.
// Throughput is one word per clock while out_tready does not stall the output.
// From input accept to result valid: the first register holds the scaled dot
// count (one constant multiply), the second stage adds it to the accumulator,
// compares against the line length and updates the counters into the result
// register. The accumulator feedback through that add and compare is the one
// loop that sets the cycle time. Configuration writes take effect at once and
// should be issued only while no word is in flight.
module video_line_frame_timing import vlft_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [9:0] cpu_cycles, [15:10] zero
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [0] hblank, [1] vblank, [2] odd_line,
                                           // [11:3] line_number, [15:12] zero
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  vlft_cfg_t         cfg_r;
  vlft_dots_t        stage;
  logic              take;
  logic              hblank;
  logic              vblank;
  logic              odd_line;
  logic [LINE_W-1:0] line_number;

  // Always accept config; an index past the map is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VIDEO_STANDARD: cfg_r.video_standard   <= cfg_data;
        REG_VERTICAL_480:   cfg_r.vertical_480     <= cfg_data;
        REG_INTERLACE:      cfg_r.interlace_enable <= cfg_data;
        default:            cfg_r                  <= cfg_r;
      endcase
    end
  end

  // Stage one: scale cycles to dots and hold them.
  vlft_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cycles    (in_tdata[CYCLES_W-1:0]),
    .take      (take),
    .stage     (stage)
  );

  // Stage two: advance the line/frame counters and register the result.
  vlft_timing u_timing (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .stage       (stage),
    .take        (take),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .hblank      (hblank),
    .vblank      (vblank),
    .odd_line    (odd_line),
    .line_number (line_number)
  );

  assign out_tdata = {4'b0000, line_number, odd_line, vblank, hblank};

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the video line and frame timing block.
module tb_top import vlft_pkg::*; ();

  // Dot clocks per CPU cycle, as a ratio; the quotient is truncated per word.
  localparam int unsigned DOT_NUM = 11;
  localparam int unsigned DOT_DEN = 7;
  localparam int unsigned CYCLES_MAX = (1 << CYCLES_W) - 1;

  // Two register stages from input accept to result valid; settle a few more.
  localparam int unsigned PIPE_SETTLE = 6;
  // Longest legal quiet stretch is the forced output stall plus a long gap,
  // so give the watchdog several times that.
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PRINT_LIMIT    = 40;

  // One result word as it should appear on out_tdata.
  typedef struct packed {
    logic              hblank;
    logic              vblank;
    logic              odd_line;
    logic [LINE_W-1:0] line_number;
  } timing_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;   // [9:0] cpu_cycles, [15:10] zero
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;  // [0] hblank, [1] vblank, [2] odd_line,
                                    // [11:3] line_number, [15:12] zero
  logic                 cfg_valid;
  logic                 cfg_ready;
  vlft_reg_t            cfg_index;
  logic                 cfg_data;

  video_line_frame_timing u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow of the timing state and of the three mode registers.
  logic [ACC_W-1:0]  dots_acc;
  logic [LINE_W-1:0] cur_line;
  logic              cur_odd;
  logic              mode_pal;
  logic              mode_480;
  logic              mode_interlace;

  // Results owed by the block, oldest first.
  timing_t pending_timing[$];

  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned lines_done;
  int unsigned frames_done;
  int unsigned mismatches;
  int unsigned idle_cycles;

  // Random idling on both sides; cleared for stretches of back-to-back traffic.
  bit          idle_on;
  // Forced output stall, counted down by the sink process.
  int unsigned hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Fast mode keeps most words near the top of the range so lines and frames
  // complete quickly; the rest is any count, small counts, zeros that move nothing and the maximum.
  function automatic logic [CYCLES_W-1:0] pick_cycles(input bit fast);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (fast) begin
      if (r < 85) return CYCLES_W'($urandom_range(850, CYCLES_MAX));
      if (r < 90) return CYCLES_W'($urandom_range(0, CYCLES_MAX));
      if (r < 95) return CYCLES_W'($urandom_range(1, 31));
      if (r < 98) return '0;
      return CYCLES_W'(CYCLES_MAX);
    end
    if (r < 80) return CYCLES_W'($urandom_range(0, CYCLES_MAX));
    if (r < 90) return CYCLES_W'($urandom_range(1, 15));
    return '0;
  endfunction

  // Advance the shadow timing by one word and return the result it causes.
  function automatic timing_t advance_timing(input logic [CYCLES_W-1:0] cycles);
    logic [ACC_W-1:0]  line_len;
    logic [LINE_W-1:0] last_line;
    int unsigned       dots;
    timing_t           r;
    line_len  = mode_pal ? DOTS_PAL : DOTS_NTSC;
    last_line = mode_pal ? LAST_LINE_PAL : LAST_LINE_NTSC;
    dots      = (int'(cycles) * DOT_NUM) / DOT_DEN;
    r         = '0;
    dots_acc  = dots_acc + ACC_W'(dots);
    // The line completes only once the accumulator is strictly past the length.
    if (dots_acc > line_len) begin
      dots_acc = dots_acc - line_len;
      cur_line = cur_line + 1'b1;
      r.hblank = 1'b1;
      lines_done++;
      // Take parity from the incremented line before any wrap.
      if (mode_480) cur_odd = cur_line[0];
      if (cur_line > last_line) begin
        cur_line = '0;
        // The field toggle needs both interlace and 480-line mode.
        if (mode_interlace && mode_480) cur_odd = ~cur_odd;
        r.vblank = 1'b1;
        frames_done++;
      end
    end
    r.odd_line    = cur_odd;
    r.line_number = cur_line;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("MISMATCH at result %0d: %s got %0d, expected %0d",
               results_checked, what, got, want);
  endtask

  task automatic check_timing(input logic [15:0] word);
    timing_t want;
    if (pending_timing.size() == 0) begin
      report_mismatch("result word with none pending, word", word, 0);
    end else begin
      want = pending_timing.pop_front();
      if (word[0] !== want.hblank)
        report_mismatch("hblank", word[0], want.hblank);
      if (word[1] !== want.vblank)
        report_mismatch("vblank", word[1], want.vblank);
      if (word[2] !== want.odd_line)
        report_mismatch("odd_line", word[2], want.odd_line);
      if (word[3 +: LINE_W] !== want.line_number)
        report_mismatch("line_number", word[3 +: LINE_W], want.line_number);
    end
    results_checked++;
  endtask

  // Check every word taken from the result stream. Sampled at the edge, so
  // the values seen are the ones the block acted on.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_timing(out_tdata);
  end

  // Sink: random stalls, plus a forced hold when a test asks for one.
  initial begin
    out_tready <= 1'b0;
    forever begin : sink_loop
      int unsigned stall_left;
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word, after a random gap when idling is on, and predict its result once accepted.
  // Leave in_tvalid high on return so back-to-back words need no extra edge.
  task automatic send_word(input logic [CYCLES_W-1:0] cycles);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(16 - CYCLES_W){1'b0}}, cycles};
    do @(posedge clk); while (!in_tready);
    pending_timing.push_back(advance_timing(cycles));
    words_sent++;
  endtask

  // Drop valid and hold until every owed result has come back and the
  // pipe is empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_timing.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Write one mode register; call only while the block is settled.
  task automatic write_reg(input vlft_reg_t idx, input logic value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_VIDEO_STANDARD: mode_pal       = value;
      REG_VERTICAL_480:   mode_480       = value;
      REG_INTERLACE:      mode_interlace = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_random(input int unsigned count, input bit fast);
    repeat (count) send_word(pick_cycles(fast));
  endtask

  task automatic run_to_frame_wrap();
    int unsigned start;
    start = frames_done;
    while (frames_done == start) send_word(pick_cycles(1'b1));
  endtask

  // Extremes of the count, single bits, and the exact-line-length boundary.
  task automatic test_directed_edges();
    send_word('0);
    send_word(10'h3FF);
    send_word(10'h3FF);
    // 1607 + 1607 + 198 lands exactly on 3412: no line yet.
    send_word(10'd126);
    // One more dot pushes it past the length.
    send_word(10'd1);
    send_word(10'h155);
    send_word(10'h2AA);
    for (int i = 0; i < CYCLES_W; i++) send_word(CYCLES_W'(1 << i));
    // Counts around the 11/7 truncation.
    send_word(10'd6);
    send_word(10'd7);
    send_word(10'd13);
    send_word(10'd14);
    settle();
  endtask

  // Default NTSC progressive mode: odd bit must hold.
  task automatic test_progressive_ntsc();
    send_random(150, 1'b0);
    settle();
  endtask

  // NTSC 480-line interlaced: parity per line, field toggle at the wrap.
  task automatic test_interlaced_ntsc();
    write_reg(REG_VIDEO_STANDARD, 1'b0);
    write_reg(REG_VERTICAL_480, 1'b1);
    write_reg(REG_INTERLACE, 1'b1);
    // Run a back-to-back stretch first, then idle at random.
    idle_on = 1'b0;
    send_random(150, 1'b1);
    idle_on = 1'b1;
    run_to_frame_wrap();
    // Stop on an odd line so the next test starts with the bit set.
    do send_word(pick_cycles(1'b1)); while (!cur_odd);
    settle();
  endtask

  // PAL with interlace but not 480 lines: the odd bit holds its value.
  // Climb past the NTSC last line for the standard switch that follows.
  task automatic test_interlace_without_480();
    write_reg(REG_VIDEO_STANDARD, 1'b1);
    write_reg(REG_VERTICAL_480, 1'b0);
    while (cur_line < LINE_W'(280)) send_word(pick_cycles(1'b1));
    settle();
  endtask

  // Switch to NTSC mid-frame above its last line: wrap on the next line.
  task automatic test_standard_switch();
    write_reg(REG_VIDEO_STANDARD, 1'b0);
    run_to_frame_wrap();
    send_random(20, 1'b0);
    settle();
  endtask

  // PAL 480-line without interlace: parity of line 315 survives the wrap.
  task automatic test_pal_480();
    write_reg(REG_VIDEO_STANDARD, 1'b1);
    write_reg(REG_VERTICAL_480, 1'b1);
    write_reg(REG_INTERLACE, 1'b0);
    run_to_frame_wrap();
    send_random(20, 1'b1);
    settle();
  endtask

  // Hold off the output while words keep coming so the block fills and
  // stalls its input, then drain.
  task automatic test_backpressure();
    idle_on     = 1'b0;
    hold_cycles = HOLD_CYCLES;
    send_random(200, 1'b1);
    idle_on = 1'b1;
    settle();
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_VIDEO_STANDARD;
    cfg_data       <= 1'b0;
    dots_acc        = '0;
    cur_line        = '0;
    cur_odd         = 1'b0;
    mode_pal        = 1'b0;
    mode_480        = 1'b0;
    mode_interlace  = 1'b0;
    words_sent      = 0;
    results_checked = 0;
    lines_done      = 0;
    frames_done     = 0;
    mismatches      = 0;
    idle_cycles     = 0;
    hold_cycles     = 0;
    idle_on         = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_progressive_ntsc();
    test_interlaced_ntsc();
    test_interlace_without_480();
    test_standard_switch();
    test_pal_480();
    test_backpressure();

    $display("Checked %0d results from %0d input words: %0d lines, %0d frame wraps.",
             results_checked, words_sent, lines_done, frames_done);
    $display("Covered NTSC and PAL, progressive, 480-line and interlaced modes, a %s",
             "mid-frame standard switch and a long output stall.");
    if (mismatches == 0 && pending_timing.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results still owed", mismatches,
               pending_timing.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/vlft_pkg.sv
design/vlft_scale.sv
design/vlft_timing.sv
design/video_line_frame_timing.sv
tb/sv/tb_top.sv
